FILE: sv/tlms_pkg.sv
package tlms_pkg;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_COMMAND  = 2'd0,
    OP_EDGE     = 2'd1,
    OP_TIMEOUT  = 2'd2,
    OP_ABNORMAL = 2'd3
  } op_e;

  // command codes
  typedef enum logic {
    CMD_RAISE = 1'b0,
    CMD_LOWER = 1'b1
  } cmd_e;

  // decoded barrier position
  typedef enum logic [1:0] {
    POS_DOWN    = 2'd0,
    POS_FWD     = 2'd1,
    POS_UPRIGHT = 2'd2,
    POS_BACK    = 2'd3
  } pos_e;

  // motion in progress
  typedef enum logic [1:0] {
    ACT_IDLE      = 2'd0,
    ACT_RAISE     = 2'd1,
    ACT_LOWER     = 2'd2,
    ACT_LOWER_INT = 2'd3
  } action_e;

  // reply codes
  typedef enum logic [2:0] {
    RPL_RUNNING = 3'd0,
    RPL_OK      = 3'd1,
    RPL_NOTHING = 3'd2,
    RPL_US_ERR  = 3'd3,
    RPL_BLOCKED = 3'd4,
    RPL_NONE    = 3'd5
  } reply_e;

  // drive level codes, bit 0 forward, bit 1 backward
  localparam logic [1:0] DRV_OFF      = 2'b00;
  localparam logic [1:0] DRV_FORWARD  = 2'b01;
  localparam logic [1:0] DRV_BACKWARD = 2'b10;

  // timeout lengths
  localparam logic [3:0] TICKS_SHORT = 4'd4;
  localparam logic [3:0] TICKS_MID   = 4'd6;
  localparam logic [3:0] TICKS_LONG  = 4'd8;

  // notify code of a successful action
  localparam logic [2:0] NCODE_OK = 3'd0;

  typedef struct packed {
    logic [1:0]  operation;
    logic        command;
    logic        sensor_up;
    logic        sensor_down;
    logic        recheck_up;
    logic        recheck_down;
    logic        edge_on_sensor_pin;
    logic [15:0] distance_cm;
    logic        distance_fault;
    logic        skip_check;
    logic        lock_busy;
  } in_item_t;

  typedef struct packed {
    logic [2:0] reply_code;
    logic       drive_forward;
    logic       drive_backward;
    logic       timer_start;
    logic [3:0] timer_ticks;
    logic       notify;
    logic [2:0] notify_code;
    logic       still_in_progress;
    logic       abnormal;
    logic [1:0] position;
  } out_item_t;

  // sequencer state carried between items
  typedef struct packed {
    action_e    action;
    pos_e       rec_pos;
    pos_e       stop_pos;
    logic [1:0] drive;
  } seq_state_t;

  // sensor levels to position
  function automatic pos_e decode_pos(input logic up, input logic down);
    pos_e p;
    if (up) begin
      p = down ? POS_FWD : POS_DOWN;
    end else begin
      p = down ? POS_UPRIGHT : POS_BACK;
    end
    return p;
  endfunction

endpackage

FILE: sv/tlms_in_if.sv
interface tlms_in_if;
  import tlms_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: sv/tlms_out_if.sv
interface tlms_out_if;
  import tlms_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: sv/tlms_cfg_if.sv
interface tlms_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/tlms_decide.sv
module tlms_decide
  import tlms_pkg::*;
(
  input  in_item_t   item_i,
  input  seq_state_t state_i,
  input  logic [7:0] safe_dist_i,
  output seq_state_t state_o,
  output out_item_t  result_o
);

  pos_e       pos;
  pos_e       recheck;
  logic       too_close;
  logic [2:0] reply;
  logic       tstart;
  logic [3:0] ticks;
  logic       notify;
  logic [2:0] ncode;
  logic       still;
  logic       abn;

  assign pos       = decode_pos(item_i.sensor_up, item_i.sensor_down);
  assign recheck   = decode_pos(item_i.recheck_up, item_i.recheck_down);
  assign too_close = item_i.distance_cm < {8'd0, safe_dist_i};

  // per-operation decision and next state
  always_comb begin
    state_o = state_i;
    reply   = RPL_NONE;
    tstart  = 1'b0;
    ticks   = 4'd0;
    notify  = 1'b0;
    ncode   = NCODE_OK;
    still   = 1'b0;
    abn     = 1'b0;
    unique case (op_e'(item_i.operation))
      OP_COMMAND: begin
        if (state_i.action != ACT_IDLE) begin
          reply = RPL_RUNNING;
        end else begin
          state_o.rec_pos = pos;
          reply = RPL_OK;
          if (cmd_e'(item_i.command) == CMD_RAISE) begin
            if (pos == POS_DOWN || pos == POS_FWD) begin
              state_o.stop_pos = POS_BACK;
            end else if (pos == POS_BACK) begin
              state_o.stop_pos = POS_FWD;
            end
            if (pos == POS_FWD) begin
              state_o.action = ACT_LOWER_INT;
              state_o.drive  = DRV_BACKWARD;
              tstart = 1'b1;
              ticks  = TICKS_SHORT;
            end else if (pos != POS_UPRIGHT && item_i.distance_fault) begin
              reply = RPL_US_ERR;
            end else if (pos != POS_UPRIGHT && too_close) begin
              reply = RPL_BLOCKED;
            end else if (pos == POS_BACK) begin
              state_o.action = ACT_RAISE;
              state_o.drive  = DRV_BACKWARD;
              tstart = 1'b1;
              ticks  = TICKS_LONG;
            end else if (pos == POS_DOWN) begin
              state_o.action = ACT_RAISE;
              state_o.drive  = DRV_FORWARD;
              tstart = 1'b1;
              ticks  = TICKS_MID;
            end else begin
              notify = 1'b1;
              reply  = RPL_NOTHING;
            end
          end else begin
            if (pos != POS_DOWN) begin
              state_o.action = ACT_LOWER;
              state_o.drive  = DRV_BACKWARD;
              tstart = 1'b1;
              ticks  = (pos == POS_BACK) ? TICKS_LONG : TICKS_MID;
            end else begin
              notify = 1'b1;
              reply  = RPL_NOTHING;
            end
          end
        end
      end
      OP_EDGE: begin
        if (state_i.action != ACT_IDLE && item_i.edge_on_sensor_pin) begin
          if (state_i.action == ACT_RAISE) begin
            if (pos == POS_UPRIGHT || pos == state_i.stop_pos) begin
              state_o.drive   = DRV_OFF;
              state_o.rec_pos = POS_UPRIGHT;
              state_o.action  = ACT_IDLE;
              notify = 1'b1;
            end
          end else if (pos == POS_DOWN && recheck == POS_DOWN) begin
            state_o.drive   = DRV_OFF;
            state_o.rec_pos = POS_DOWN;
            state_o.action  = ACT_IDLE;
            notify = 1'b1;
            still  = (state_i.action == ACT_LOWER_INT);
          end
        end
      end
      OP_TIMEOUT: begin
        if (state_i.action != ACT_IDLE) begin
          state_o.drive   = DRV_OFF;
          state_o.rec_pos = pos;
          state_o.action  = ACT_IDLE;
          notify = 1'b1;
          ncode  = 3'd1 + {1'b0, pos};
          still  = (state_i.action == ACT_LOWER_INT) && (pos == POS_DOWN);
        end
      end
      OP_ABNORMAL: begin
        if (!item_i.skip_check && !item_i.lock_busy && pos != state_i.rec_pos) begin
          state_o.rec_pos = pos;
          abn = 1'b1;
        end
      end
      default: begin
        reply = RPL_NONE;
      end
    endcase
  end

  // result item
  always_comb begin
    result_o.reply_code        = reply;
    result_o.drive_forward     = state_o.drive[0];
    result_o.drive_backward    = state_o.drive[1];
    result_o.timer_start       = tstart;
    result_o.timer_ticks       = ticks;
    result_o.notify            = notify;
    result_o.notify_code       = ncode;
    result_o.still_in_progress = still;
    result_o.abnormal          = abn;
    result_o.position          = pos;
  end

endmodule

FILE: sv/tilt_lock_motor_sequencer_core.sv
// channel   direction  contents
// in_i      sink       one event item: operation, sensor levels, distance, flags
// out_o     source     one result item per event: reply, drive, timer, notice
// cfg_i     sink       safe_distance_cm write data, always ready
//
// an item waits in the input register and is decided on the way into the result
// register, from which its result leaves; one item per cycle sustained while
// out_o is ready; the only loop is the state register update
// reset clears the state to idle, position down, drive off, safe distance 0
// a stalled result holds in the output register while one more item waits in
// the input register; input ready drops only when both are full
module tilt_lock_motor_sequencer_core
  import tlms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tlms_in_if.sink    in_i,
  tlms_out_if.source out_o,
  tlms_cfg_if.sink   cfg_i
);

  logic       in_v_q;
  in_item_t   in_q;
  logic       out_v_q;
  logic       out_v_d;
  out_item_t  out_q;
  seq_state_t state_q;
  seq_state_t state_d;
  out_item_t  result;
  logic [7:0] safe_q;
  logic       adv;

  // item moves from input register to result register
  assign adv         = in_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready  = !in_v_q || adv;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_v_q;
  assign out_o.item  = out_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safe_q <= 8'd0;
    end else if (cfg_i.valid) begin
      safe_q <= cfg_i.data;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.item;
    end
  end

  // decision logic
  tlms_decide u_decide (
    .item_i      (in_q),
    .state_i     (state_q),
    .safe_dist_i (safe_q),
    .state_o     (state_d),
    .result_o    (result)
  );

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{action: ACT_IDLE, rec_pos: POS_DOWN, stop_pos: POS_DOWN, drive: DRV_OFF};
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  // result register
  always_comb begin
    if (adv) begin
      out_v_d = 1'b1;
    end else if (out_o.ready) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= result;
    end
  end

`ifndef SYNTHESIS
  // motor never driven both ways
  a_drive_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.drive != 2'b11)
    else $error("both drive lines on");

  // drive is on exactly while a motion is active
  a_idle_drive_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.action == ACT_IDLE) == (state_q.drive == DRV_OFF))
    else $error("drive level and action disagree");

  // a started timeout always comes with a driven motor
  a_timer_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.timer_start) |-> (out_q.drive_forward || out_q.drive_backward))
    else $error("timer started with motor off");

  // an item leaving the input register lands in the result register
  a_advance_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_v_q)
    else $error("result register missed an item");
`endif

endmodule
